// File: rtl/core/crm_pkg.sv
`timescale 1ns / 1ps
// crm_pkg: shared types and constants of the color ramp interpolator.
// No dependencies; imported by every crm_* module and the core top level.
package crm_pkg;

    localparam int STOP_COUNT   = 8;
    localparam int STOP_IDX_W   = 3;
    localparam int THR_W        = 17;   // unsigned Q1.16 threshold, may exceed 1.0
    localparam int CHAN_W       = 8;
    localparam int CHAN_COUNT   = 3;
    localparam int SAMPLE_W     = 24;   // signed Q7.16
    localparam int FRAC_W       = 16;   // interpolation fraction, Q0.16
    localparam int CFG_W        = 41;   // threshold plus packed color
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;    // 8 registers at 8-byte stride
    localparam int CFG_ADDR_LSB = 3;
    localparam int DIV_STEPS_DEF = 4;   // quotient bits resolved per divider stage

    // Channel slots inside rgb_t, matching the register packing.
    localparam int CHAN_RED   = 2;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 0;

    typedef logic [CHAN_COUNT-1:0][CHAN_W-1:0] rgb_t;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        rgb_t             color;
    } stop_t;

    // Payload carried through the divider pipeline.
    typedef struct packed {
        logic [THR_W-1:0]  rem;
        logic [THR_W-1:0]  den;
        logic [FRAC_W-1:0] quo;
        rgb_t              col_lo;
        rgb_t              col_hi;
    } div_slot_t;

endpackage

// File: rtl/core/crm_regs.sv
`timescale 1ns / 1ps
// crm_regs: APB register file holding the eight color stops.
// Depends on crm_pkg.
module crm_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crm_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [crm_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [crm_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,
    output crm_pkg::stop_t [crm_pkg::STOP_COUNT-1:0] stops
);
    import crm_pkg::*;

    stop_t [STOP_COUNT-1:0] stops_reg;
    logic  [STOP_IDX_W-1:0] reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[CFG_ADDR_LSB +: STOP_IDX_W];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stops_reg <= '0;
        end
        else if (wr_en)
        begin
            stops_reg[reg_idx] <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = {{(CFG_DATA_W-CFG_W){1'b0}}, stops_reg[reg_idx]};
    assign pready = 1'b1;
    assign stops  = stops_reg;

endmodule

// File: rtl/core/crm_select.sv
`timescale 1ns / 1ps
// crm_select: threshold compare stage and segment select stage.
// Depends on crm_pkg; feeds crm_divider.
module crm_select (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic [crm_pkg::SAMPLE_W-1:0]             sample,
    input  crm_pkg::stop_t [crm_pkg::STOP_COUNT-1:0] stops,
    output logic                                     sel_valid,
    output crm_pkg::div_slot_t                       sel_slot
);
    import crm_pkg::*;

    localparam int PAD_W = SAMPLE_W - 1 - THR_W;

    logic                  s1_valid_reg;
    logic [SAMPLE_W-1:0]   s1_sample_reg;
    logic [STOP_COUNT-1:0] s1_lt_reg;
    logic [STOP_COUNT-1:0] lt_next;

    logic [STOP_COUNT-1:0] first_hit;
    logic                  prefix;
    logic                  hit_any;
    logic                  exact;
    stop_t                 stop_lo;
    stop_t                 stop_hi;
    div_slot_t             slot_next;

    logic                  s2_valid_reg;
    div_slot_t             s2_slot_reg;

    // thr < sample; a negative sample is below every threshold
    always_comb
    begin
        for (int k = 0; k < STOP_COUNT; k++)
        begin
            lt_next[k] = !sample[SAMPLE_W-1] &&
                ({{PAD_W{1'b0}}, stops[k].thr} < sample[SAMPLE_W-2:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= sample;
        s1_lt_reg     <= lt_next;
    end

    // first stop in index order whose threshold is not below the sample
    always_comb
    begin
        prefix = 1'b1;
        for (int k = 0; k < STOP_COUNT; k++)
        begin
            first_hit[k] = prefix && !s1_lt_reg[k];
            prefix       = prefix && s1_lt_reg[k];
        end
    end

    always_comb
    begin
        stop_hi = '0;
        stop_lo = '0;
        for (int k = 0; k < STOP_COUNT; k++)
        begin
            if (first_hit[k])
            begin
                stop_hi = stop_hi | stops[k];
            end
        end
        for (int k = 1; k < STOP_COUNT; k++)
        begin
            if (first_hit[k])
            begin
                stop_lo = stop_lo | stops[k-1];
            end
        end
    end

    assign hit_any = |first_hit;
    assign exact   = !s1_sample_reg[SAMPLE_W-1] &&
                     ({{PAD_W{1'b0}}, stop_hi.thr} == s1_sample_reg[SAMPLE_W-2:0]);

    // Direct colors travel as lo == hi, so the blend returns them unchanged.
    always_comb
    begin
        slot_next = '0;
        if (!hit_any)
        begin
            slot_next.col_lo = stops[STOP_COUNT-1].color;
            slot_next.col_hi = stops[STOP_COUNT-1].color;
        end
        else if (first_hit[0] || exact)
        begin
            slot_next.col_lo = stop_hi.color;
            slot_next.col_hi = stop_hi.color;
        end
        else
        begin
            // thr_lo < sample < thr_hi, so both differences fit THR_W bits
            slot_next.rem    = s1_sample_reg[THR_W-1:0] - stop_lo.thr;
            slot_next.den    = stop_hi.thr - stop_lo.thr;
            slot_next.col_lo = stop_lo.color;
            slot_next.col_hi = stop_hi.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_slot_reg <= slot_next;
    end

    assign sel_valid = s2_valid_reg;
    assign sel_slot  = s2_slot_reg;

endmodule

// File: rtl/core/crm_divider.sv
`timescale 1ns / 1ps
// crm_divider: pipelined restoring divider producing the Q0.16 fraction.
// Depends on crm_pkg; DIV_STEPS quotient bits per stage, must divide FRAC_W.
module crm_divider #(
    parameter int DIV_STEPS = crm_pkg::DIV_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               div_in_valid,
    input  crm_pkg::div_slot_t div_in,
    output logic               div_out_valid,
    output crm_pkg::div_slot_t div_out
);
    import crm_pkg::*;

    localparam int DIV_STAGES = FRAC_W / DIV_STEPS;

    logic      [DIV_STAGES-1:0] valid_reg;
    div_slot_t                  stage_reg [DIV_STAGES];

    // One quotient bit: remainder stays below den, so it fits THR_W bits.
    function automatic div_slot_t div_step(input div_slot_t cur);
        div_slot_t        nxt;
        logic [THR_W:0]   rem2;
        nxt  = cur;
        rem2 = {cur.rem, 1'b0};
        if (rem2 >= {1'b0, cur.den})
        begin
            nxt.rem = THR_W'(rem2 - {1'b0, cur.den});
            nxt.quo = {cur.quo[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = rem2[THR_W-1:0];
            nxt.quo = {cur.quo[FRAC_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    for (genvar st = 0; st < DIV_STAGES; st++)
    begin : g_stage
        div_slot_t stage_in;
        div_slot_t stage_next;
        logic      valid_in;

        if (st == 0)
        begin : g_first
            assign stage_in = div_in;
            assign valid_in = div_in_valid;
        end
        else
        begin : g_rest
            assign stage_in = stage_reg[st-1];
            assign valid_in = valid_reg[st-1];
        end

        always_comb
        begin
            stage_next = stage_in;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                stage_next = div_step(stage_next);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[st] <= 1'b0;
            end
            else
            begin
                valid_reg[st] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[st] <= stage_next;
        end
    end

    assign div_out_valid = valid_reg[DIV_STAGES-1];
    assign div_out       = stage_reg[DIV_STAGES-1];

endmodule

// File: rtl/core/crm_blend.sv
`timescale 1ns / 1ps
// crm_blend: weights the two stop colors by the fraction and sums them.
// Depends on crm_pkg; multiply stage then sum and output register stage.
module crm_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               bl_in_valid,
    input  crm_pkg::div_slot_t bl_in,
    output logic               bl_out_valid,
    output crm_pkg::rgb_t      bl_out
);
    import crm_pkg::*;

    localparam int WGT_W  = FRAC_W + 1;
    localparam int PROD_W = WGT_W + CHAN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

    logic [WGT_W-1:0]  wgt_lo;
    logic [WGT_W-1:0]  wgt_hi;
    logic [PROD_W-1:0] prod_lo_next [CHAN_COUNT];
    logic [PROD_W-1:0] prod_hi_next [CHAN_COUNT];
    logic [PROD_W-1:0] prod_lo_reg  [CHAN_COUNT];
    logic [PROD_W-1:0] prod_hi_reg  [CHAN_COUNT];
    logic              m_valid_reg;

    logic [SUM_W-1:0]  sum          [CHAN_COUNT];
    rgb_t              color_next;
    rgb_t              color_reg;
    logic              out_valid_reg;

    assign wgt_hi = {1'b0, bl_in.quo};
    assign wgt_lo = WGT_ONE - wgt_hi;

    always_comb
    begin
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            prod_lo_next[c] = PROD_W'(bl_in.col_lo[c]) * PROD_W'(wgt_lo);
            prod_hi_next[c] = PROD_W'(bl_in.col_hi[c]) * PROD_W'(wgt_hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg   <= bl_in_valid;
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        color_reg   <= color_next;
    end

    // sum never exceeds 255 * 2^16, truncating shift keeps the integer part
    always_comb
    begin
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            sum[c]        = {1'b0, prod_lo_reg[c]} + {1'b0, prod_hi_reg[c]};
            color_next[c] = sum[c][FRAC_W +: CHAN_W];
        end
    end

    assign bl_out_valid = out_valid_reg;
    assign bl_out       = color_reg;

endmodule

// File: rtl/core/color_ramp_interpolator_core.sv
`timescale 1ns / 1ps
// color_ramp_interpolator_core: top level of the color ramp interpolator.
// Depends on crm_pkg, crm_regs, crm_select, crm_divider and crm_blend.
//
// Usage:
//   Samples (signed Q7.16) enter on the command port: a transfer happens at a
//   rising edge with start high and busy low. busy stays low, so one sample
//   may be issued on every clock.
//   Each sample yields one RGB result on red/green/blue, shown for exactly one
//   cycle with done high. Results leave in issue order.
//   Each sample passes, in order, through compare, segment select,
//   16/DIV_STEPS divider stages, multiply and sum; done rises with the
//   registered sum and the result transfers on the next edge.
//   Throughput is one sample per clock; the restoring divider is fully
//   pipelined at DIV_STEPS quotient bits a stage.
//   Stops are written through the APB port, register i at byte address 8*i,
//   threshold in bits 40:24 and color in bits 23:0. Write them only while
//   no sample is in flight.
//   Reset clears all stops to zero and empties the pipeline; in-flight
//   samples are dropped. The receiver cannot stall: results must be taken
//   on the cycle they are shown.
module color_ramp_interpolator_core #(
    parameter int DIV_STEPS = crm_pkg::DIV_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [crm_pkg::SAMPLE_W-1:0]    sample,
    output logic                            done,
    output logic [crm_pkg::CHAN_W-1:0]      red,
    output logic [crm_pkg::CHAN_W-1:0]      green,
    output logic [crm_pkg::CHAN_W-1:0]      blue,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [crm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [crm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import crm_pkg::*;

    stop_t [STOP_COUNT-1:0] stops;
    logic                   in_valid;
    logic                   sel_valid;
    div_slot_t              sel_slot;
    logic                   div_valid;
    div_slot_t              div_slot;
    logic                   blend_valid;
    rgb_t                   blend_color;

    // Fully pipelined, no backpressure: every start is a transfer.
    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    crm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .stops   (stops)
    );

    // Stages 1-2: threshold compares, then pick the segment and its operands.
    crm_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .sample    (sample),
        .stops     (stops),
        .sel_valid (sel_valid),
        .sel_slot  (sel_slot)
    );

    // Fraction = (offset << 16) / span; direct colors pass through, and with lo == hi the fraction has no effect.
    crm_divider #(
        .DIV_STEPS (DIV_STEPS)
    ) u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .div_in_valid  (sel_valid),
        .div_in        (sel_slot),
        .div_out_valid (div_valid),
        .div_out       (div_slot)
    );

    // Last two stages: weighted products, then sum and truncate.
    crm_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .bl_in_valid  (div_valid),
        .bl_in        (div_slot),
        .bl_out_valid (blend_valid),
        .bl_out       (blend_color)
    );

    assign done  = blend_valid;
    assign red   = blend_color[CHAN_RED];
    assign green = blend_color[CHAN_GREEN];
    assign blue  = blend_color[CHAN_BLUE];

endmodule
